// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers; the checks drop out when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds on every clock edge out of reset
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: always");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: implication");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next cycle");

`else

`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLIES(label, pre, post)
`define ASSERT_NEXT(label, pre, post)

`endif

`endif

// ===== hdl/lpfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfr_pkg
// constants, types and the crc bit step of the frame receiver
// ----------------------------------------------------------------------------
package lpfr_pkg;

    localparam int FRAME_MAX = 64;
    localparam int POS_W     = $clog2(FRAME_MAX + 1);
    localparam int ADDR_W    = $clog2(FRAME_MAX);
    localparam int IDX_W     = 6;
    localparam int LEN_MIN   = 2;
    localparam int LEN_MAX   = FRAME_MAX - 2;

    localparam logic [7:0] CRC_POLY = 8'hD5;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRC,
        S_RD,
        S_LOAD,
        S_FAIL
    } state_t;

    // one bit of the msb-first crc-8 division
    function automatic logic [7:0] crc_bit_step(input logic [7:0] crc);
        logic [7:0] shifted;
        shifted = {crc[6:0], 1'b0};
        if ((crc & CRC_TOP) != 8'h00)
        begin
            return shifted ^ CRC_POLY;
        end
        return shifted;
    endfunction

endpackage

// ===== hdl/lpfr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lpfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/length_prefixed_frame_receiver_crc8.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_crc8
// serial frame receiver: address, length, type and payload, crc-8 check
// ----------------------------------------------------------------------------
// Takes one received byte per request and rebuilds address/length/body/crc
// frames in a 64-byte store. Address, length and crc bytes are taken with
// no crc step; every type or payload byte holds the input while it is
// stored and then run bit by bit through the bit-serial crc-8 (0xD5) unit.
// A good frame is then replayed from the store one byte at a time (ram
// read, then load of the output register), waiting while the output stalls,
// and the input stays stalled until the last byte is loaded. A crc mismatch
// gives a single failure marker; a good frame that arrives while frame_pending
// is high is dropped. The store needs no clearing after reset, so the block
// takes bytes from the first cycle out of reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module length_prefixed_frame_receiver_crc8
    import lpfr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       rx_byte,
    input  logic             frame_pending,

    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       frame_byte,
    output logic [IDX_W-1:0] byte_index,
    output logic             last,
    output logic             status
);

    state_t             state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   exp_reg, exp_next;
    logic [7:0]         crc_reg, crc_next;
    logic [2:0]         bit_cnt_reg, bit_cnt_next;
    logic [ADDR_W-1:0]  emit_idx_reg, emit_idx_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic [IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic               out_last_reg, out_last_next;
    logic               out_status_reg, out_status_next;

    logic               ram_we;
    logic               ram_re;
    logic [7:0]         ram_rdata;

    logic               accept;
    logic               out_free;
    logic               len_bad;
    logic               guard_hit;
    logic [POS_W-1:0]   pos_inc;
    logic               frame_done;
    logic               crc_ok;
    logic               emit_last;

    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign len_bad    = (rx_byte < 8'(LEN_MIN)) || (rx_byte > 8'(LEN_MAX));
    assign guard_hit  = (pos_reg >= POS_W'(FRAME_MAX)) || (exp_reg == '0)
                        || (pos_reg >= exp_reg);
    assign pos_inc    = pos_reg + POS_W'(1);
    assign frame_done = (pos_inc >= exp_reg);
    assign crc_ok     = (crc_reg == rx_byte);
    assign emit_last  = ((POS_W'(emit_idx_reg) + POS_W'(1)) == exp_reg);

    lpfr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_MAX)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg[ADDR_W-1:0]),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (emit_idx_reg),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (pos_reg > POS_W'(1)) && !guard_hit)
                begin
                    priority if (!frame_done)
                    begin
                        state_next = S_CRC;
                    end
                    else if (!crc_ok)
                    begin
                        state_next = S_FAIL;
                    end
                    else if (!frame_pending)
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_CRC:
            begin
                if (bit_cnt_reg == 3'd7)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    state_next = emit_last ? S_IDLE : S_RD;
                end
            end
            S_FAIL:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        in_stall        = (state_reg != S_IDLE);
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        pos_next        = pos_reg;
        exp_next        = exp_reg;
        crc_next        = crc_reg;
        bit_cnt_next    = bit_cnt_reg;
        emit_idx_next   = emit_idx_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_byte_next   = out_byte_reg;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (pos_reg == '0)
                    begin
                        ram_we   = 1'b1;
                        pos_next = POS_W'(1);
                        exp_next = '0;
                        crc_next = 8'h00;
                    end
                    else if (pos_reg == POS_W'(1))
                    begin
                        if (len_bad)
                        begin
                            pos_next = '0;
                            exp_next = '0;
                        end
                        else
                        begin
                            ram_we   = 1'b1;
                            pos_next = POS_W'(2);
                            exp_next = POS_W'(rx_byte) + POS_W'(2);
                        end
                        crc_next = 8'h00;
                    end
                    else if (guard_hit)
                    begin
                        pos_next = '0;
                        exp_next = '0;
                        crc_next = 8'h00;
                    end
                    else if (!frame_done)
                    begin
                        ram_we       = 1'b1;
                        pos_next     = pos_inc;
                        crc_next     = crc_reg ^ rx_byte;
                        bit_cnt_next = 3'd0;
                    end
                    else
                    begin
                        // crc byte: stored; exp_reg is kept for the replay of a good frame with no frame_pending
                        ram_we        = 1'b1;
                        pos_next      = '0;
                        crc_next      = 8'h00;
                        emit_idx_next = '0;
                        if (!crc_ok || frame_pending)
                        begin
                            exp_next = '0;
                        end
                    end
                end
            end
            S_CRC:
            begin
                crc_next     = crc_bit_step(crc_reg);
                bit_cnt_next = bit_cnt_reg + 3'd1;
            end
            S_RD:
            begin
                ram_re = 1'b1;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = ram_rdata;
                    out_idx_next    = IDX_W'(emit_idx_reg);
                    out_last_next   = emit_last;
                    out_status_next = 1'b0;
                    emit_idx_next   = emit_idx_reg + ADDR_W'(1);
                    if (emit_last)
                    begin
                        exp_next = '0;
                    end
                end
            end
            S_FAIL:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = 8'h00;
                    out_idx_next    = '0;
                    out_last_next   = 1'b1;
                    out_status_next = 1'b1;
                end
            end
            default:
            begin
                pos_next = '0;
                exp_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            exp_reg       <= '0;
            crc_reg       <= 8'h00;
            bit_cnt_reg   <= 3'd0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            exp_reg       <= exp_next;
            crc_reg       <= crc_next;
            bit_cnt_reg   <= bit_cnt_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        out_idx_reg    <= out_idx_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign byte_index = out_idx_reg;
    assign last       = out_last_reg;
    assign status     = out_status_reg;

    `ASSERT_ALWAYS(a_pos_in_range, pos_reg <= POS_W'(FRAME_MAX))
    `ASSERT_IMPLIES(a_fail_marker_shape, out_valid && status, last && (frame_byte == 8'h00))
    `ASSERT_NEXT(a_crc_eight_steps, (state_reg == S_CRC) && (bit_cnt_reg == 3'd7), state_reg == S_IDLE)
    `ASSERT_IMPLIES(a_replay_within_frame, (state_reg == S_RD) || (state_reg == S_LOAD), (exp_reg >= POS_W'(4)) && (POS_W'(emit_idx_reg) < exp_reg))

endmodule

// ===== tb/length_prefixed_frame_receiver_crc8_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_crc8_tb
// self-checking bench for the length-prefixed crc-8 frame receiver
// ----------------------------------------------------------------------------
// Feeds address/length/body/crc byte streams through the valid/stall input
// and rebuilds every frame in a software copy of the receiver, which queues
// the replayed bytes or the crc failure marker that each completed frame
// should give. Every output request is checked field by field against the
// oldest queued entry. A few directed frames cover the length limits, crc
// failures and dropped frames; random frames, bad lengths and stray bytes
// follow, with random idling on both sides, one calm stretch, one long
// output hold-off and one pause until the output has drained.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver_crc8_tb
    import lpfr_pkg::*;
();

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int ITEM_TARGET     = 160;
    localparam int PRINT_CAP       = 40;

    typedef struct packed {
        logic [7:0]       fbyte;
        logic [IDX_W-1:0] idx;
        logic             fin;
        logic             crc_bad;
    } frame_out_t;

    class deframer_scoreboard;
        bit [7:0]   fill;
        bit [7:0]   frame_len;
        bit [7:0]   crc_acc;
        bit [7:0]   store [FRAME_MAX];
        frame_out_t due_q [$];
        int         mismatches;
        int         good_frames;
        int         crc_fails;
        int         pend_drops;
        int         len_drops;
        int         results_seen;

        function bit [7:0] crc_after(bit [7:0] crc, bit [7:0] b);
            bit [7:0] c;
            c = crc ^ b;
            for (int i = 0; i < 8; i++)
            begin
                c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
            end
            return c;
        endfunction

        function void restart();
            fill      = 0;
            frame_len = 0;
            crc_acc   = 0;
        endfunction

        function bit mid_frame();
            return fill != 0;
        endfunction

        function int outstanding();
            return due_q.size();
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= PRINT_CAP)
            begin
                $display("%0t mismatch: %s", $realtime, what);
            end
        endtask

        // one accepted input request
        function void note_rx_byte(bit [7:0] b, bit pend);
            frame_out_t r;
            if (fill == 0)
            begin
                store[0]  = b;
                fill      = 1;
                frame_len = 0;
                crc_acc   = 0;
                return;
            end
            if (fill == 1)
            begin
                if (b < LEN_MIN || b > LEN_MAX)
                begin
                    len_drops++;
                    restart();
                    return;
                end
                store[1]  = b;
                fill      = 2;
                frame_len = 8'(b + 2);
                crc_acc   = 0;
                return;
            end
            // overrun guard, unreachable with a legal length
            if (fill >= FRAME_MAX || frame_len == 0 || fill >= frame_len)
            begin
                restart();
                return;
            end
            store[fill] = b;
            fill++;
            if (fill < frame_len)
            begin
                crc_acc = crc_after(crc_acc, b);
                return;
            end
            if (crc_acc != b)
            begin
                r = '{fbyte: 8'h00, idx: '0, fin: 1'b1, crc_bad: 1'b1};
                due_q.push_back(r);
                crc_fails++;
            end
            else if (pend)
            begin
                pend_drops++;
            end
            else
            begin
                for (int k = 0; k < frame_len; k++)
                begin
                    r = '{fbyte: store[k], idx: IDX_W'(k), fin: (k == frame_len - 1),
                          crc_bad: 1'b0};
                    due_q.push_back(r);
                end
                good_frames++;
            end
            restart();
        endfunction

        task check_frame_out(logic [7:0] fb, logic [IDX_W-1:0] ix, logic fin, logic st);
            frame_out_t want;
            results_seen++;
            if (due_q.size() == 0)
            begin
                report($sformatf("unexpected result byte=%0h idx=%0d last=%0b status=%0b",
                                 fb, ix, fin, st));
                return;
            end
            want = due_q.pop_front();
            if (fb !== want.fbyte)
                report($sformatf("frame_byte %0h, wanted %0h", fb, want.fbyte));
            if (ix !== want.idx)
                report($sformatf("byte_index %0d, wanted %0d", ix, want.idx));
            if (fin !== want.fin)
                report($sformatf("last %0b, wanted %0b", fin, want.fin));
            if (st !== want.crc_bad)
                report($sformatf("status %0b, wanted %0b", st, want.crc_bad));
        endtask
    endclass

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             in_valid      = 1'b0;
    logic             in_stall;
    logic [7:0]       rx_byte       = 8'h00;
    logic             frame_pending = 1'b0;
    logic             out_valid;
    logic             out_stall     = 1'b0;
    logic [7:0]       frame_byte;
    logic [IDX_W-1:0] byte_index;
    logic             last;
    logic             status;

    deframer_scoreboard sb = new();
    int items_sent    = 0;
    int hold_off_asked = 0;
    bit calm          = 1'b0;

    length_prefixed_frame_receiver_crc8 dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .frame_pending (frame_pending),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_byte    (frame_byte),
        .byte_index    (byte_index),
        .last          (last),
        .status        (status)
    );

    always #5 clk = ~clk;

    // entered and left at a falling edge
    task automatic send_request(input bit [7:0] b, input bit pend);
        while (!calm && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        rx_byte       <= b;
        frame_pending <= pend;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_rx_byte(b, pend);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input bit [7:0] addr, input int len, input bit bad_crc,
                              input bit pend);
        bit [7:0] crc;
        bit [7:0] b;
        crc = 8'h00;
        send_request(addr, 1'($urandom_range(1)));
        send_request(8'(len), 1'($urandom_range(1)));
        for (int k = 0; k < len - 1; k++)
        begin
            b   = 8'($urandom);
            crc = sb.crc_after(crc, b);
            send_request(b, 1'($urandom_range(1)));
        end
        if (bad_crc)
            crc ^= 8'($urandom_range(255, 1));
        send_request(crc, pend);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    // output side: random stall, calm stretch, and one long hold-off
    initial
    begin
        int given;
        given = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_asked != given)
            begin
                given++;
                out_stall <= 1'b1;
                for (int n = 1; n < HOLD_OFF_CYCLES; n++)
                    @(negedge clk);
            end
            else if (calm)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 35);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_frame_out(frame_byte, byte_index, last, status);
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int       sel;
        int       len;
        bit [7:0] len_byte;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // shortest frame, all-ones type byte
        send_request(8'h00, 1'b0);
        send_request(8'd2, 1'b1);
        send_request(8'hFF, 1'b1);
        send_request(sb.crc_after(8'h00, 8'hFF), 1'b0);
        // crc failures, pending has no effect on them
        send_frame(8'hFF, 2, 1'b1, 1'b0);
        send_frame(8'($urandom), 3, 1'b1, 1'b1);
        // lengths just outside the legal range, and a length of zero
        send_request(8'h5A, 1'b0);
        send_request(8'd1, 1'b0);
        send_request(8'hA5, 1'b1);
        send_request(8'(LEN_MAX + 1), 1'b1);
        send_request(8'h11, 1'b0);
        send_request(8'h00, 1'b0);
        // good frame dropped while the previous one is still pending
        send_frame(8'($urandom), 2, 1'b0, 1'b1);
        wait_drained();

        for (int fi = 0; items_sent < ITEM_TARGET; fi++)
        begin
            if (fi == 2)
                hold_off_asked++;
            calm = (fi >= 8 && fi < 14);
            if (fi == 16)
                wait_drained();
            // stray bytes leave the receiver mid-frame: finish that frame first
            while (sb.mid_frame())
                send_request(8'($urandom), 1'($urandom_range(1)));
            sel = $urandom_range(99);
            len = ($urandom_range(99) < 3) ? LEN_MAX : $urandom_range(LEN_MIN, 8);
            if (fi == 4)
                send_frame(8'($urandom), LEN_MAX, 1'b0, 1'b0);
            else if (sel < 70)
                send_frame(8'($urandom), len, 1'b0, $urandom_range(4) == 0);
            else if (sel < 82)
                send_frame(8'($urandom), len, 1'b1, 1'($urandom_range(1)));
            else if (sel < 91)
            begin
                case ($urandom_range(3))
                    0: len_byte = 8'h00;
                    1: len_byte = 8'h01;
                    default: len_byte = 8'($urandom_range(255, LEN_MAX + 1));
                endcase
                send_request(8'($urandom), 1'($urandom_range(1)));
                send_request(len_byte, 1'($urandom_range(1)));
            end
            else
            begin
                repeat ($urandom_range(3, 1))
                    send_request(8'($urandom), 1'($urandom_range(1)));
            end
        end
        calm = 1'b0;
        wait_drained();
        repeat (200) @(posedge clk);

        if (sb.outstanding() != 0)
            sb.report($sformatf("%0d results never arrived", sb.outstanding()));
        $display("run: %0d bytes sent, %0d good frames, %0d crc failures, %0d pending drops,",
                 items_sent, sb.good_frames, sb.crc_fails, sb.pend_drops);
        $display("     %0d bad lengths, %0d output bytes checked, %0d mismatches",
                 sb.len_drops, sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lpfr_pkg.sv
hdl/lpfr_ram.sv
hdl/length_prefixed_frame_receiver_crc8.sv
tb/length_prefixed_frame_receiver_crc8_tb.sv
